// File: hw/rtl/acrms_pkg.sv
package acrms_pkg;

    localparam int SAMPLE_BITS_DEF = 16;
    localparam int COUNT_BITS_DEF  = 16;
    localparam int TIME_BITS       = 32;
    localparam int SUM_BITS        = 48;
    localparam int QUEUE_DEPTH     = 2;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_DIVIDE,
        BK_ROOT,
        BK_OUTPUT
    } bk_state_t;

endpackage

// File: hw/rtl/acrms_if.sv
interface acrms_if #(
    parameter int PAYLOAD_BITS = 8
);
    logic                    valid;
    logic                    ready;
    logic [PAYLOAD_BITS-1:0] payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

// File: hw/rtl/acrms_front.sv
module acrms_front
    import acrms_pkg::*;
#(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
    parameter int COUNT_BITS  = COUNT_BITS_DEF,
    parameter int REC_BITS    = 8
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [SAMPLE_BITS-1:0] sample,
    input  logic [TIME_BITS-1:0]   sample_time,
    output logic                rec_valid,
    input  logic                rec_ready,
    output logic [REC_BITS-1:0] rec
);

    localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};
    localparam logic [SUM_BITS-1:0]   SUM_MAX   = {SUM_BITS{1'b1}};

    // stage 1 holds the sample and its square, stage 2 is the accumulator
    logic signed [SAMPLE_BITS-1:0]   prev_reg;
    logic                            armed_reg;
    logic [TIME_BITS-1:0]            end_time_reg;
    logic signed [SAMPLE_BITS-1:0]   max_reg, min_reg;
    logic [SUM_BITS-1:0]             sum_reg;
    logic [COUNT_BITS-1:0]           count_reg;

    logic                            p_valid_reg;
    logic                            p_done_reg;
    logic signed [SAMPLE_BITS-1:0]   p_sample_reg;
    logic [2*SAMPLE_BITS-1:0]        p_sq_reg;

    logic [TIME_BITS-1:0]            pend_begin_reg;

    logic signed [SAMPLE_BITS-1:0] s;
    logic done;
    logic take;

    logic signed [SAMPLE_BITS-1:0] b_max, b_min;
    logic [SUM_BITS-1:0]           b_sum;
    logic [COUNT_BITS-1:0]         b_count;
    logic [SUM_BITS:0]             sum_add;

    assign s        = $signed(sample);
    assign in_ready = !p_valid_reg || !p_done_reg || rec_ready;
    assign take     = in_valid && in_ready;

    always_comb
    begin
        done = armed_reg && !s[SAMPLE_BITS-1] && !prev_reg[SAMPLE_BITS-1];
    end

    // record: end time, max, min, sum, count, begin time
    assign rec_valid = p_valid_reg && p_done_reg;
    assign rec = {end_time_reg, max_reg, min_reg, sum_reg, count_reg, pend_begin_reg};

    always_comb
    begin
        b_max   = max_reg;
        b_min   = min_reg;
        b_sum   = sum_reg;
        b_count = count_reg;
        if (p_done_reg)
        begin
            b_max   = '0;
            b_min   = '0;
            b_sum   = '0;
            b_count = '0;
        end
        if (p_sample_reg > b_max)
            b_max = p_sample_reg;
        else if (p_sample_reg < b_min)
            b_min = p_sample_reg;
        sum_add = {1'b0, b_sum} + (SUM_BITS+1)'(p_sq_reg);
        if (b_count != COUNT_MAX)
        begin
            b_sum   = sum_add[SUM_BITS] ? SUM_MAX : sum_add[SUM_BITS-1:0];
            b_count = b_count + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_reg       <= '0;
            armed_reg      <= 1'b0;
            end_time_reg   <= '0;
            pend_begin_reg <= '0;
            max_reg        <= '0;
            min_reg        <= '0;
            sum_reg        <= '0;
            count_reg      <= '0;
            p_valid_reg    <= 1'b0;
            p_done_reg     <= 1'b0;
            p_sample_reg   <= '0;
            p_sq_reg       <= '0;
        end
        else
        begin
            // retire stage 1 into the accumulators (record already taken if done)
            if (p_valid_reg && (!p_done_reg || rec_ready))
            begin
                max_reg     <= b_max;
                min_reg     <= b_min;
                sum_reg     <= b_sum;
                count_reg   <= b_count;
                p_valid_reg <= 1'b0;
            end
            if (take)
            begin
                p_valid_reg  <= 1'b1;
                p_done_reg   <= done;
                p_sample_reg <= s;
                p_sq_reg     <= (2*SAMPLE_BITS)'(s * s);
                prev_reg     <= s;
                armed_reg    <= prev_reg[SAMPLE_BITS-1] && !s[SAMPLE_BITS-1];
                if (done)
                begin
                    end_time_reg   <= sample_time;
                    pend_begin_reg <= end_time_reg;
                end
            end
        end
    end

endmodule

// File: hw/rtl/acrms_back.sv
module acrms_back
    import acrms_pkg::*;
#(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
    parameter int COUNT_BITS  = COUNT_BITS_DEF,
    parameter int REC_BITS    = 8
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   rec_valid,
    output logic                   rec_ready,
    input  logic [REC_BITS-1:0]    rec,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic [SAMPLE_BITS-1:0] rms_value,
    output logic [SAMPLE_BITS-2:0] half_peak_to_peak,
    output logic [SAMPLE_BITS-2:0] positive_peak,
    output logic [SAMPLE_BITS-1:0] negative_peak,
    output logic [COUNT_BITS-1:0]  cycle_samples,
    output logic [TIME_BITS-1:0]   cycle_start_us,
    output logic [TIME_BITS-1:0]   period_us
);

    localparam int QBITS = $clog2(SUM_BITS + 1);
    localparam int RBITS = SUM_BITS / 2;
    localparam int RCNT  = $clog2(RBITS + 1);

    bk_state_t state_reg, state_next;

    logic [TIME_BITS-1:0]          end_r, begin_r;
    logic signed [SAMPLE_BITS-1:0] max_r, min_r;
    logic [COUNT_BITS-1:0]         cnt_r;
    logic [SUM_BITS-1:0]           quo_reg;
    logic [COUNT_BITS:0]           rem_reg;
    logic [QBITS-1:0]              step_reg;
    logic [SUM_BITS-1:0]           rad_reg;
    logic [RBITS+1:0]              rrem_reg;
    logic [RBITS-1:0]              root_reg;
    logic [RCNT-1:0]               rstep_reg;

    logic [TIME_BITS-1:0]          in_end, in_begin;
    logic signed [SAMPLE_BITS-1:0] in_max, in_min;
    logic [SUM_BITS-1:0]           in_sum;
    logic [COUNT_BITS-1:0]         in_cnt;

    assign {in_end, in_max, in_min, in_sum, in_cnt, in_begin} = rec;

    logic [COUNT_BITS:0] rem_sh, rem_sub;
    logic [RBITS+1:0]    rr_sh, rr_trial;
    logic [SAMPLE_BITS:0] span;

    always_comb
    begin
        rem_sh   = {rem_reg[COUNT_BITS-1:0], quo_reg[SUM_BITS-1]};
        rem_sub  = rem_sh - {1'b0, cnt_r};
        rr_sh    = {rrem_reg[RBITS-1:0], rad_reg[SUM_BITS-1:SUM_BITS-2]};
        rr_trial = {root_reg, 2'b01};
        span     = (SAMPLE_BITS+1)'(max_r) - (SAMPLE_BITS+1)'(min_r);
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            BK_IDLE:   if (rec_valid) state_next = BK_DIVIDE;
            BK_DIVIDE: if (step_reg == QBITS'(SUM_BITS - 1)) state_next = BK_ROOT;
            BK_ROOT:   if (rstep_reg == RCNT'(RBITS - 1)) state_next = BK_OUTPUT;
            BK_OUTPUT: if (out_ready) state_next = BK_IDLE;
            default:   state_next = BK_IDLE;
        endcase
    end

    always_comb
    begin
        rec_ready = (state_reg == BK_IDLE);
        out_valid = (state_reg == BK_OUTPUT);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= BK_IDLE;
        else
            state_reg <= state_next;
    end

    // restoring divide one bit a step, then root two bits a step
    always_ff @(posedge clk)
    begin
        case (state_reg)
            BK_IDLE:
            begin
                end_r    <= in_end;
                begin_r  <= in_begin;
                max_r    <= in_max;
                min_r    <= in_min;
                cnt_r    <= in_cnt;
                quo_reg  <= in_sum;
                rem_reg  <= '0;
                step_reg <= '0;
            end
            BK_DIVIDE:
            begin
                step_reg <= step_reg + 1'b1;
                if (!rem_sub[COUNT_BITS])
                begin
                    rem_reg <= rem_sub;
                    quo_reg <= {quo_reg[SUM_BITS-2:0], 1'b1};
                end
                else
                begin
                    rem_reg <= rem_sh;
                    quo_reg <= {quo_reg[SUM_BITS-2:0], 1'b0};
                end
                if (step_reg == QBITS'(SUM_BITS - 1))
                begin
                    rrem_reg  <= '0;
                    root_reg  <= '0;
                    rstep_reg <= '0;
                    if (cnt_r == '0)
                        rad_reg <= '0;
                    else
                        rad_reg <= {quo_reg[SUM_BITS-2:0], !rem_sub[COUNT_BITS]};
                end
            end
            BK_ROOT:
            begin
                rstep_reg <= rstep_reg + 1'b1;
                rad_reg   <= {rad_reg[SUM_BITS-3:0], 2'b00};
                if (rr_sh >= rr_trial)
                begin
                    rrem_reg <= rr_sh - rr_trial;
                    root_reg <= {root_reg[RBITS-2:0], 1'b1};
                end
                else
                begin
                    rrem_reg <= rr_sh;
                    root_reg <= {root_reg[RBITS-2:0], 1'b0};
                end
            end
            default:
            begin
            end
        endcase
    end

    assign rms_value         = root_reg[SAMPLE_BITS-1:0];
    assign half_peak_to_peak = span[SAMPLE_BITS-1:1];
    assign positive_peak     = max_r[SAMPLE_BITS-2:0];
    assign negative_peak     = min_r;
    assign cycle_samples     = cnt_r;
    assign cycle_start_us    = begin_r;
    assign period_us         = end_r - begin_r;

    a_one_side: assert property (@(posedge clk) disable iff (!rst_n)
        !(out_valid && rec_ready))
        else $error("output and intake both open");
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(rms_value))
        else $error("result lost while stalled");
    a_take: assert property (@(posedge clk) disable iff (!rst_n)
        rec_valid && rec_ready |=> state_reg == BK_DIVIDE)
        else $error("record not started");

endmodule

// File: hw/rtl/ac_cycle_rms_peak_meter_core.sv
// Per-cycle true-RMS and peak meter. One sample item is taken per clock unless
// a closing sample is waiting for the back end; the front accumulates squares,
// peaks and count with one 16x16 multiply stage. When a cycle closes, the
// finished cycle record is handed to the back end, which runs a 48-step
// restoring divide and a 24-step square root and then presents one result
// item. The back end takes no new record until its result has been taken.
// The front holds a closing sample until the back end is free, so cycles
// that close before the previous record is done stall the input.
module ac_cycle_rms_peak_meter_core
    import acrms_pkg::*;
#(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
    parameter int COUNT_BITS  = COUNT_BITS_DEF
)
(
    input  logic clk,
    input  logic rst_n,
    acrms_if.sink   in_ch,
    acrms_if.source out_ch
);

    localparam int REC_BITS = 3*TIME_BITS + 2*SAMPLE_BITS + SUM_BITS + COUNT_BITS
                              - TIME_BITS;

    logic                rec_valid, rec_ready;
    logic [REC_BITS-1:0] rec;

    logic [SAMPLE_BITS-1:0] rms_value;
    logic [SAMPLE_BITS-2:0] half_peak_to_peak, positive_peak;
    logic [SAMPLE_BITS-1:0] negative_peak;
    logic [COUNT_BITS-1:0]  cycle_samples;
    logic [TIME_BITS-1:0]   cycle_start_us, period_us;

    acrms_front #(.SAMPLE_BITS(SAMPLE_BITS), .COUNT_BITS(COUNT_BITS),
                  .REC_BITS(REC_BITS)) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_ch.valid),
        .in_ready     (in_ch.ready),
        .sample       (in_ch.payload[SAMPLE_BITS-1:0]),
        .sample_time  (in_ch.payload[SAMPLE_BITS +: TIME_BITS]),
        .rec_valid    (rec_valid),
        .rec_ready    (rec_ready),
        .rec          (rec)
    );

    acrms_back #(.SAMPLE_BITS(SAMPLE_BITS), .COUNT_BITS(COUNT_BITS),
                 .REC_BITS(REC_BITS)) u_back (
        .clk               (clk),
        .rst_n             (rst_n),
        .rec_valid         (rec_valid),
        .rec_ready         (rec_ready),
        .rec               (rec),
        .out_valid         (out_ch.valid),
        .out_ready         (out_ch.ready),
        .rms_value         (rms_value),
        .half_peak_to_peak (half_peak_to_peak),
        .positive_peak     (positive_peak),
        .negative_peak     (negative_peak),
        .cycle_samples     (cycle_samples),
        .cycle_start_us    (cycle_start_us),
        .period_us         (period_us)
    );

    assign out_ch.payload = {period_us, cycle_start_us, cycle_samples, negative_peak,
                             positive_peak, half_peak_to_peak, rms_value};

endmodule

// File: tb/tb.sv
`timescale 1ns / 1ps

module tb;
    import acrms_pkg::*;

    localparam int IN_BITS  = 16 + 32;
    localparam int OUT_BITS = 16 + 15 + 15 + 16 + 16 + 32 + 32;
    localparam logic [47:0] SUM_LIMIT = 48'hFFFF_FFFF_FFFF;
    localparam logic [15:0] COUNT_LIMIT = 16'hFFFF;

    typedef struct packed {
        logic [31:0] period_us;
        logic [31:0] cycle_start_us;
        logic [15:0] cycle_samples;
        logic [15:0] negative_peak;
        logic [14:0] positive_peak;
        logic [14:0] half_peak_to_peak;
        logic [15:0] rms_value;
    } cycle_report_t;

    logic clk;
    logic rst_n;

    acrms_if #(.PAYLOAD_BITS(IN_BITS))  in_ch ();
    acrms_if #(.PAYLOAD_BITS(OUT_BITS)) out_ch ();

    ac_cycle_rms_peak_meter_core i_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch)
    );

    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    logic [IN_BITS-1:0] sample_queue[$];
    cycle_report_t      report_queue[$];
    int  idle_pct;
    int  stall_pct;
    bit  hold_input;
    int  error_count;
    int  items_taken;
    int  reports_seen;
    logic [31:0] stamp;

    // Predictor state
    logic signed [15:0] last_sample;
    bit                 armed;
    logic [31:0]        begin_time;
    logic [31:0]        end_time;
    logic signed [15:0] peak_hi;
    logic signed [15:0] peak_lo;
    logic [47:0]        energy;
    logic [15:0]        tally;

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $time);
        error_count++;
    endtask

    function automatic logic [15:0] floor_root(input logic [47:0] x);
        logic [24:0] r;
        logic [24:0] t;
        r = '0;
        for (int i = 23; i >= 0; i--)
        begin
            t = r | (25'd1 << i);
            if ({25'd0, t} * {25'd0, t} <= {2'd0, x})
                r = t;
        end
        return r[15:0];
    endfunction

    task automatic push_sample(input logic signed [15:0] s, input int unsigned step);
        stamp = stamp + step;
        sample_queue.push_back({stamp, s});
    endtask

    // One AC cycle: positive half then negative half, random shape
    task automatic push_wave(input int len, input int amp);
        int half;
        half = (len < 2) ? 1 : len / 2;
        for (int i = 0; i < len; i++)
        begin
            if (i < half)
                push_sample(16'($urandom_range(amp, 0)), $urandom_range(600, 1));
            else
                push_sample(-16'($urandom_range(amp + 1, 1)), $urandom_range(600, 1));
        end
    endtask

    always @(posedge clk)
    begin
        logic signed [15:0] s;
        logic [31:0]        ts;
        bit                 closing;
        cycle_report_t      r;
        logic [16:0]        span;
        logic [31:0]        sq;
        if (rst_n && in_ch.valid && in_ch.ready)
        begin
            s = in_ch.payload[15:0];
            ts = in_ch.payload[47:16];
            items_taken++;
            closing = 1'b0;
            if (last_sample < 0 && s >= 0)
                armed = 1'b1;
            else if (armed && s >= 0)
            begin
                begin_time = end_time;
                end_time = ts;
                armed = 1'b0;
                closing = 1'b1;
            end
            else
                armed = 1'b0;
            last_sample = s;
            if (closing)
            begin
                span = 17'(peak_hi) - 17'(peak_lo);
                r.rms_value = (tally == 0) ? 16'd0 : floor_root(energy / tally);
                r.half_peak_to_peak = span[15:1];
                r.positive_peak = peak_hi[14:0];
                r.negative_peak = peak_lo;
                r.cycle_samples = tally;
                r.cycle_start_us = begin_time;
                r.period_us = end_time - begin_time;
                report_queue.push_back(r);
                peak_hi = '0;
                peak_lo = '0;
                energy = '0;
                tally = '0;
            end
            if (s > peak_hi)
                peak_hi = s;
            else if (s < peak_lo)
                peak_lo = s;
            if (tally < COUNT_LIMIT)
            begin
                sq = 32'(s * s);
                energy = (energy > SUM_LIMIT - sq) ? SUM_LIMIT : energy + sq;
                tally++;
            end
        end
    end

    // Driver: advance on acceptance, idle at random
    always @(posedge clk)
    begin
        if (!rst_n)
            in_ch.valid <= 1'b0;
        else if (!in_ch.valid || in_ch.ready)
        begin
            if (!hold_input && sample_queue.size() != 0 && $urandom_range(99, 0) >= idle_pct)
            begin
                in_ch.payload <= sample_queue.pop_front();
                in_ch.valid <= 1'b1;
            end
            else
                in_ch.valid <= 1'b0;
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n)
            out_ch.ready <= 1'b0;
        else
            out_ch.ready <= ($urandom_range(99, 0) >= stall_pct);
    end

    always @(posedge clk)
    begin
        cycle_report_t got;
        cycle_report_t want;
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            got = out_ch.payload;
            reports_seen++;
            if (report_queue.size() == 0)
            begin
                $display("unexpected result item at %0t", $time);
                error_count++;
            end
            else
            begin
                want = report_queue.pop_front();
                if (got.rms_value != want.rms_value)
                    report_mismatch("rms_value", 64'(got.rms_value), 64'(want.rms_value));
                if (got.half_peak_to_peak != want.half_peak_to_peak)
                    report_mismatch("half_peak_to_peak", 64'(got.half_peak_to_peak),
                                    64'(want.half_peak_to_peak));
                if (got.positive_peak != want.positive_peak)
                    report_mismatch("positive_peak", 64'(got.positive_peak),
                                    64'(want.positive_peak));
                if (got.negative_peak != want.negative_peak)
                    report_mismatch("negative_peak", 64'(got.negative_peak),
                                    64'(want.negative_peak));
                if (got.cycle_samples != want.cycle_samples)
                    report_mismatch("cycle_samples", 64'(got.cycle_samples),
                                    64'(want.cycle_samples));
                if (got.cycle_start_us != want.cycle_start_us)
                    report_mismatch("cycle_start_us", 64'(got.cycle_start_us),
                                    64'(want.cycle_start_us));
                if (got.period_us != want.period_us)
                    report_mismatch("period_us", 64'(got.period_us), 64'(want.period_us));
            end
        end
    end

    task automatic drain();
        while (sample_queue.size() != 0 || in_ch.valid)
            @(posedge clk);
        while (report_queue.size() != 0)
            @(posedge clk);
    endtask

    task automatic random_phase(input int idle, input int stall, input int n);
        int sent;
        idle_pct = idle;
        stall_pct = stall;
        sent = 0;
        while (sent < n)
        begin
            case ($urandom_range(9, 0))
                0:
                begin
                    // noise
                    for (int i = 0; i < 6; i++)
                        push_sample(16'($urandom), $urandom_range(3, 0) == 0 ? $urandom : 7);
                    sent += 6;
                end
                1:
                begin
                    // broken crossing: rise then fall back
                    push_sample(-16'sd3, 9);
                    push_sample(16'sd2, 9);
                    push_sample(-16'($urandom_range(32768, 1)), 9);
                    sent += 3;
                end
                default:
                begin
                    automatic int len = $urandom_range(30, 3);
                    push_wave(len, $urandom_range(1, 0) ? 32767 : $urandom_range(300, 0));
                    sent += len;
                end
            endcase
        end
        drain();
    endtask

    initial
    begin
        in_ch.valid = 1'b0;
        in_ch.payload = '0;
        out_ch.ready = 1'b0;
        hold_input = 1'b0;
        idle_pct = 0;
        stall_pct = 0;
        error_count = 0;
        items_taken = 0;
        reports_seen = 0;
        last_sample = '0;
        armed = 1'b0;
        begin_time = '0;
        end_time = '0;
        peak_hi = '0;
        peak_lo = '0;
        energy = '0;
        tally = '0;
        stamp = 32'hFFFF_FFF0;
        rst_n = 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: extremes, first cycle, re-armed crossing, time wrap
        push_sample(-16'sd32768, 4);
        push_sample(16'sd32767, 4);
        push_sample(16'sd0, 4);
        push_sample(-16'sd1, 4);
        push_sample(16'sd0, 4);
        push_sample(-16'sd5, 4);
        push_sample(16'sd1, 4);
        push_sample(16'sd32767, 4);
        push_sample(16'sd0, 4);
        push_sample(-16'sd32768, 32'h7FFF_FFFF);
        push_sample(-16'sd32768, 32'h8000_0000);
        push_sample(16'sd0, 1);
        push_sample(16'sd0, 1);
        push_sample(-16'sd2, 1);
        push_sample(16'sd5, 1);
        push_sample(16'sd6, 1);
        drain();

        // Hold the input back while a wave is queued, then release it
        hold_input = 1'b1;
        push_wave(8, 1000);
        repeat (100) @(posedge clk);
        hold_input = 1'b0;

        random_phase(0, 0, 225);
        random_phase(75, 0, 225);
        random_phase(0, 75, 225);
        random_phase(28, 28, 225);
        repeat (200) @(posedge clk);

        $display("covered %0d sample items and %0d cycle reports", items_taken, reports_seen);
        $display("phases: directed edges, free flow, sender gaps, receiver stalls, both");
        if (error_count == 0 && report_queue.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    initial
    begin
        #20_000_000;
        $display("timeout at %0t", $time);
        $display("RESULT: ERROR");
        $finish;
    end

endmodule
